// File: hw/rtl/tusc_pkg.sv
`default_nettype none

package tusc_pkg;

    // Field widths.
    localparam int PIX_W    = 31;            // non-negative pixel counts and unpack registers
    localparam int ALIGN_W  = 8;             // row alignment register
    localparam int AMASK_W  = 3;             // alignment minus one, alignment at most 8
    localparam int BPP_W    = 5;             // bytes per pixel, at most 16
    localparam int ROWT_W   = 36;            // row bytes before and after rounding up
    localparam int HALF_W   = ROWT_W / 2;    // row bytes are split in halves for the multipliers
    localparam int PP_W     = PIX_W + HALF_W;
    localparam int BASE_W   = ROWT_W + 1;
    localparam int EXT_W    = 70;            // exact width of every intermediate sum
    localparam int BYTES_W  = 64;
    localparam int STATUS_W = 3;

    // Size limit: every intermediate value has to fit in SIZE_WIDTH bits.
    localparam int SIZE_WIDTH = 64;
    localparam logic [EXT_W-1:0] SIZE_MAX =
        ({{(EXT_W-1){1'b0}}, 1'b1} << SIZE_WIDTH) - {{(EXT_W-1){1'b0}}, 1'b1};

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_STRIDE        = 2'd0;
    localparam logic [1:0] REG_SKIP_PX       = 2'd1;
    localparam logic [1:0] REG_SKIP_LINES    = 2'd2;
    localparam logic [1:0] REG_ROW_ALIGNMENT = 2'd3;

    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 8'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_NEG    = 3'd1,
        ST_WINDOW = 3'd2,
        ST_FMT    = 3'd3,
        ST_ALIGN  = 3'd4,
        ST_OVF    = 3'd5
    } t_status;

    typedef struct packed {
        logic [PIX_W-1:0]   stride_px;
        logic [PIX_W-1:0]   skip_px;
        logic [PIX_W-1:0]   skip_lines;
        logic [ALIGN_W-1:0] row_alignment;
    } t_unpack_cfg;

    // GL format codes.
    localparam logic [15:0] FMT_DEPTH_COMPONENT = 16'h1902;
    localparam logic [15:0] FMT_RED             = 16'h1903;
    localparam logic [15:0] FMT_ALPHA           = 16'h1906;
    localparam logic [15:0] FMT_RGB             = 16'h1907;
    localparam logic [15:0] FMT_RGBA            = 16'h1908;
    localparam logic [15:0] FMT_LUMINANCE       = 16'h1909;
    localparam logic [15:0] FMT_LUMINANCE_ALPHA = 16'h190A;
    localparam logic [15:0] FMT_RG              = 16'h8227;
    localparam logic [15:0] FMT_RG_INTEGER      = 16'h8228;
    localparam logic [15:0] FMT_RED_INTEGER     = 16'h8D94;
    localparam logic [15:0] FMT_RGB_INTEGER     = 16'h8D98;
    localparam logic [15:0] FMT_RGBA_INTEGER    = 16'h8D99;

    // GL type codes.
    localparam logic [15:0] TYP_BYTE            = 16'h1400;
    localparam logic [15:0] TYP_UNSIGNED_BYTE   = 16'h1401;
    localparam logic [15:0] TYP_SHORT           = 16'h1402;
    localparam logic [15:0] TYP_UNSIGNED_SHORT  = 16'h1403;
    localparam logic [15:0] TYP_INT             = 16'h1404;
    localparam logic [15:0] TYP_UNSIGNED_INT    = 16'h1405;
    localparam logic [15:0] TYP_FLOAT           = 16'h1406;
    localparam logic [15:0] TYP_HALF_FLOAT      = 16'h140B;
    localparam logic [15:0] TYP_US_4_4_4_4      = 16'h8033;
    localparam logic [15:0] TYP_US_5_5_5_1      = 16'h8034;
    localparam logic [15:0] TYP_US_5_6_5        = 16'h8363;
    localparam logic [15:0] TYP_UI_2_10_10_10   = 16'h8368;
    localparam logic [15:0] TYP_UI_24_8         = 16'h84FA;
    localparam logic [15:0] TYP_UI_10F_11F_11F  = 16'h8C3B;
    localparam logic [15:0] TYP_UI_5_9_9_9      = 16'h8C3E;
    localparam logic [15:0] TYP_F32_UI_24_8     = 16'h8DAD;

    // Bytes per pixel for a format and type pair; zero marks an unsupported pair.
    function automatic logic [BPP_W-1:0] pixel_bytes(input logic [15:0] fmt,
                                                     input logic [15:0] typ);
        logic [2:0]       comps;
        logic [2:0]       csize;
        logic [BPP_W-1:0] bpp;
        comps = 3'd0;
        csize = 3'd0;
        unique case (fmt) inside
            FMT_ALPHA, FMT_LUMINANCE, FMT_RED, FMT_RED_INTEGER,
            FMT_DEPTH_COMPONENT:                          comps = 3'd1;
            FMT_LUMINANCE_ALPHA, FMT_RG, FMT_RG_INTEGER:  comps = 3'd2;
            FMT_RGB, FMT_RGB_INTEGER:                     comps = 3'd3;
            FMT_RGBA, FMT_RGBA_INTEGER:                   comps = 3'd4;
            default:                                      comps = 3'd0;
        endcase
        unique case (typ) inside
            TYP_BYTE, TYP_UNSIGNED_BYTE:                        csize = 3'd1;
            TYP_SHORT, TYP_UNSIGNED_SHORT, TYP_HALF_FLOAT:      csize = 3'd2;
            TYP_INT, TYP_UNSIGNED_INT, TYP_FLOAT:               csize = 3'd4;
            default:                                            csize = 3'd0;
        endcase
        bpp = BPP_W'(comps) * BPP_W'(csize);
        unique case (typ) inside
            TYP_US_5_6_5, TYP_US_4_4_4_4, TYP_US_5_5_5_1:       bpp = 5'd2;
            TYP_UI_2_10_10_10, TYP_UI_10F_11F_11F, TYP_UI_5_9_9_9,
            TYP_UI_24_8:                                        bpp = 5'd4;
            TYP_F32_UI_24_8:                                    bpp = 5'd8;
            default:                                            bpp = bpp;
        endcase
        return bpp;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tusc_size_pipe.sv
`default_nettype none

// Five register stages: screening and decode, row rounding, split products,
// product assembly, final sum with the overflow check.
module tusc_size_pipe (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire tusc_pkg::t_unpack_cfg           i_cfg,
    input  wire logic                            i_accept,
    input  wire logic [31:0]                     i_width,
    input  wire logic [31:0]                     i_height,
    input  wire logic [15:0]                     i_pixel_format,
    input  wire logic [15:0]                     i_component_type,
    output logic                                 o_valid,
    output logic [tusc_pkg::STATUS_W-1:0]        o_status,
    output logic [tusc_pkg::BYTES_W-1:0]         o_required_bytes
);

    // Stage 1.
    logic                              r_s1_valid;
    logic                              r_s1_done;
    tusc_pkg::t_status                 r_s1_status;
    logic [tusc_pkg::PIX_W-1:0]        r_s1_w;
    logic [tusc_pkg::PIX_W-1:0]        r_s1_hm1;
    logic [tusc_pkg::PIX_W-1:0]        r_s1_store_w;
    logic [tusc_pkg::BPP_W-1:0]        r_s1_bpp;
    logic [tusc_pkg::AMASK_W-1:0]      r_s1_amask;

    logic                              n_s1_done;
    tusc_pkg::t_status                 n_s1_status;
    logic [tusc_pkg::PIX_W-1:0]        n_s1_w;
    logic [tusc_pkg::PIX_W-1:0]        n_s1_h;
    logic [tusc_pkg::PIX_W-1:0]        n_s1_store_w;
    logic [tusc_pkg::BPP_W-1:0]        n_s1_bpp;
    logic [tusc_pkg::PIX_W:0]          n_s1_row_end;
    logic                              n_s1_align_ok;

    always_comb begin
        n_s1_w        = i_width[tusc_pkg::PIX_W-1:0];
        n_s1_h        = i_height[tusc_pkg::PIX_W-1:0];
        n_s1_store_w  = (i_cfg.stride_px == '0) ? n_s1_w : i_cfg.stride_px;
        n_s1_row_end  = {1'b0, i_cfg.skip_px} + {1'b0, n_s1_w};
        n_s1_bpp      = tusc_pkg::pixel_bytes(i_pixel_format, i_component_type);
        n_s1_align_ok = (i_cfg.row_alignment == 8'd1) || (i_cfg.row_alignment == 8'd2) ||
                        (i_cfg.row_alignment == 8'd4) || (i_cfg.row_alignment == 8'd8);
        n_s1_done     = 1'b1;
        n_s1_status   = tusc_pkg::ST_OK;
        // The first failing check decides the status.
        if (i_width[31] || i_height[31]) begin
            n_s1_status = tusc_pkg::ST_NEG;
        end else if (n_s1_row_end > {1'b0, n_s1_store_w}) begin
            n_s1_status = tusc_pkg::ST_WINDOW;
        end else if ((n_s1_w == '0) || (n_s1_h == '0)) begin
            n_s1_status = tusc_pkg::ST_OK;
        end else if (n_s1_bpp == '0) begin
            n_s1_status = tusc_pkg::ST_FMT;
        end else if (!n_s1_align_ok) begin
            n_s1_status = tusc_pkg::ST_ALIGN;
        end else begin
            n_s1_done   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_accept;
        end
        r_s1_done    <= n_s1_done;
        r_s1_status  <= n_s1_status;
        r_s1_w       <= n_s1_w;
        r_s1_hm1     <= n_s1_h - tusc_pkg::PIX_W'(1);
        r_s1_store_w <= n_s1_store_w;
        r_s1_bpp     <= n_s1_bpp;
        r_s1_amask   <= i_cfg.row_alignment[tusc_pkg::AMASK_W-1:0] - tusc_pkg::AMASK_W'(1);
    end

    // Stage 2: stored row bytes rounded up to the alignment.
    logic                              r_s2_valid;
    logic                              r_s2_done;
    tusc_pkg::t_status                 r_s2_status;
    logic                              r_s2_tovf;
    logic [tusc_pkg::ROWT_W-1:0]       r_s2_row;
    logic [tusc_pkg::PIX_W-1:0]        r_s2_hm1;
    logic [tusc_pkg::ROWT_W-1:0]       r_s2_spix;
    logic [tusc_pkg::ROWT_W-1:0]       r_s2_last;

    logic [tusc_pkg::ROWT_W-1:0]       n_s2_tsum;

    assign n_s2_tsum = tusc_pkg::ROWT_W'(r_s1_store_w) * tusc_pkg::ROWT_W'(r_s1_bpp)
                     + tusc_pkg::ROWT_W'(r_s1_amask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_done   <= r_s1_done;
        r_s2_status <= r_s1_status;
        r_s2_tovf   <= tusc_pkg::EXT_W'(n_s2_tsum) > tusc_pkg::SIZE_MAX;
        r_s2_row    <= n_s2_tsum & ~tusc_pkg::ROWT_W'(r_s1_amask);
        r_s2_hm1    <= r_s1_hm1;
        r_s2_spix   <= tusc_pkg::ROWT_W'(i_cfg.skip_px) * tusc_pkg::ROWT_W'(r_s1_bpp);
        r_s2_last   <= tusc_pkg::ROWT_W'(r_s1_w) * tusc_pkg::ROWT_W'(r_s1_bpp);
    end

    // Stage 3: row bytes are split in halves so each product stays narrow.
    logic                              r_s3_valid;
    logic                              r_s3_done;
    tusc_pkg::t_status                 r_s3_status;
    logic                              r_s3_tovf;
    logic [tusc_pkg::PP_W-1:0]         r_s3_sr_lo;
    logic [tusc_pkg::PP_W-1:0]         r_s3_sr_hi;
    logic [tusc_pkg::PP_W-1:0]         r_s3_h_lo;
    logic [tusc_pkg::PP_W-1:0]         r_s3_h_hi;
    logic [tusc_pkg::BASE_W-1:0]       r_s3_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
        r_s3_done   <= r_s2_done;
        r_s3_status <= r_s2_status;
        r_s3_tovf   <= r_s2_tovf;
        r_s3_sr_lo  <= tusc_pkg::PP_W'(i_cfg.skip_lines)
                     * tusc_pkg::PP_W'(r_s2_row[tusc_pkg::HALF_W-1:0]);
        r_s3_sr_hi  <= tusc_pkg::PP_W'(i_cfg.skip_lines)
                     * tusc_pkg::PP_W'(r_s2_row[tusc_pkg::ROWT_W-1:tusc_pkg::HALF_W]);
        r_s3_h_lo   <= tusc_pkg::PP_W'(r_s2_hm1)
                     * tusc_pkg::PP_W'(r_s2_row[tusc_pkg::HALF_W-1:0]);
        r_s3_h_hi   <= tusc_pkg::PP_W'(r_s2_hm1)
                     * tusc_pkg::PP_W'(r_s2_row[tusc_pkg::ROWT_W-1:tusc_pkg::HALF_W]);
        r_s3_base   <= tusc_pkg::BASE_W'(r_s2_spix) + tusc_pkg::BASE_W'(r_s2_last);
    end

    // Stage 4: assemble the two full products.
    logic                              r_s4_valid;
    logic                              r_s4_done;
    tusc_pkg::t_status                 r_s4_status;
    logic                              r_s4_tovf;
    logic [tusc_pkg::EXT_W-1:0]        r_s4_srows;
    logic [tusc_pkg::EXT_W-1:0]        r_s4_rest;
    logic [tusc_pkg::BASE_W-1:0]       r_s4_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
        r_s4_done   <= r_s3_done;
        r_s4_status <= r_s3_status;
        r_s4_tovf   <= r_s3_tovf;
        r_s4_srows  <= (tusc_pkg::EXT_W'(r_s3_sr_hi) << tusc_pkg::HALF_W)
                     + tusc_pkg::EXT_W'(r_s3_sr_lo);
        r_s4_rest   <= (tusc_pkg::EXT_W'(r_s3_h_hi) << tusc_pkg::HALF_W)
                     + tusc_pkg::EXT_W'(r_s3_h_lo);
        r_s4_base   <= r_s3_base;
    end

    // Stage 5: the total bounds every partial sum and product within it, so one compare
    // on the exact total covers them; the rounded row has its own flag from stage 2.
    logic [tusc_pkg::EXT_W-1:0]        n_total;
    tusc_pkg::t_status                 n_status;
    logic [tusc_pkg::BYTES_W-1:0]      n_bytes;

    always_comb begin
        n_total  = r_s4_srows + r_s4_rest + tusc_pkg::EXT_W'(r_s4_base);
        n_bytes  = '0;
        n_status = r_s4_status;
        if (!r_s4_done) begin
            if (r_s4_tovf || (n_total > tusc_pkg::SIZE_MAX)) begin
                n_status = tusc_pkg::ST_OVF;
            end else begin
                n_status = tusc_pkg::ST_OK;
                n_bytes  = n_total[tusc_pkg::BYTES_W-1:0];
            end
        end
    end

    logic                              r_out_valid;
    logic [tusc_pkg::STATUS_W-1:0]     r_out_status;
    logic [tusc_pkg::BYTES_W-1:0]      r_out_bytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s4_valid;
        end
        r_out_status <= n_status;
        r_out_bytes  <= n_bytes;
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_required_bytes = r_out_bytes;

endmodule

`default_nettype wire

// File: hw/rtl/texture_unpack_size_calc_unit.sv
// Channel   | Ports                                            | Handshake
// ----------+--------------------------------------------------+---------------------------------
// request   | i_width, i_height, i_pixel_format,               | taken when start high, busy low
//           | i_component_type                                 |
// result    | o_status, o_required_bytes                       | o_valid strobe, one cycle
// config    | psel, penable, pwrite, paddr, pwdata, prdata     | APB, pready tied high
//
// A request word is taken every clock cycle; busy never rises.
// The result word passes the five register stages of the size pipeline (the long
// products run split), and there is exactly one result word per request.
// i_rst_n is synchronous and active low; it clears all valid bits and loads the
// unpack registers with row length 0, skips 0 and alignment 4.
// The result side cannot stall, so nothing is ever held back.
`default_nettype none

module texture_unpack_size_calc_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Request channel.
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [31:0]                     i_width,
    input  wire logic [31:0]                     i_height,
    input  wire logic [15:0]                     i_pixel_format,
    input  wire logic [15:0]                     i_component_type,
    // Result channel.
    output logic                                 o_valid,
    output logic [tusc_pkg::STATUS_W-1:0]        o_status,
    output logic [tusc_pkg::BYTES_W-1:0]         o_required_bytes,
    // Configuration port.
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [3:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    // The pipeline has no back pressure of its own, so requests are never refused.
    assign busy   = 1'b0;
    assign pready = 1'b1;

    // Unpack registers. Writes keep only the low bits that each register holds.
    tusc_pkg::t_unpack_cfg r_cfg;
    logic                  cfg_wr;
    logic [1:0]            cfg_idx;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stride_px     <= '0;
            r_cfg.skip_px       <= '0;
            r_cfg.skip_lines    <= '0;
            r_cfg.row_alignment <= tusc_pkg::ALIGN_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                tusc_pkg::REG_STRIDE:
                    r_cfg.stride_px     <= pwdata[tusc_pkg::PIX_W-1:0];
                tusc_pkg::REG_SKIP_PX:
                    r_cfg.skip_px       <= pwdata[tusc_pkg::PIX_W-1:0];
                tusc_pkg::REG_SKIP_LINES:
                    r_cfg.skip_lines    <= pwdata[tusc_pkg::PIX_W-1:0];
                tusc_pkg::REG_ROW_ALIGNMENT:
                    r_cfg.row_alignment <= pwdata[tusc_pkg::ALIGN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back is combinational; the address decode covers all four slots.
    always_comb begin
        unique case (cfg_idx)
            tusc_pkg::REG_STRIDE:        prdata = 32'(r_cfg.stride_px);
            tusc_pkg::REG_SKIP_PX:       prdata = 32'(r_cfg.skip_px);
            tusc_pkg::REG_SKIP_LINES:    prdata = 32'(r_cfg.skip_lines);
            tusc_pkg::REG_ROW_ALIGNMENT: prdata = 32'(r_cfg.row_alignment);
            default:                     prdata = '0;
        endcase
    end

    // The size pipeline does all the arithmetic, and its stages read the registers directly.
    // The user must change configuration only while the pipeline is empty; nothing enforces it.
    tusc_size_pipe u_size_pipe (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_accept         (start && !busy),
        .i_width          (i_width),
        .i_height         (i_height),
        .i_pixel_format   (i_pixel_format),
        .i_component_type (i_component_type),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_required_bytes (o_required_bytes)
    );

endmodule

`default_nettype wire

// File: hw/rtl/tusc_checker.sv
`default_nettype none

module tusc_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic [31:0]                     i_width,
    input  wire logic                            o_valid,
    input  wire logic [tusc_pkg::STATUS_W-1:0]   o_status,
    input  wire logic [tusc_pkg::BYTES_W-1:0]    o_required_bytes
);

    // Every accepted request gives a result.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted request produced no result");

    // No result appears without an earlier accepted request.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 5))
        else $error("result without a matching request");

    // A negative width always ends as a negative size status.
    a_neg_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_width[31]) |-> ##5 (o_status == tusc_pkg::ST_NEG))
        else $error("negative width not reported");

    // Only a good status carries a byte count.
    a_bytes_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != tusc_pkg::ST_OK)) |-> (o_required_bytes == '0))
        else $error("byte count on a failed request");

endmodule

bind texture_unpack_size_calc_unit tusc_checker u_tusc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_width          (i_width),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_required_bytes (o_required_bytes)
);

`default_nettype wire

// File: verif/texture_unpack_size_checker.sv
`default_nettype none

module texture_unpack_size_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [31:0] i_width,
    input  wire logic [31:0] i_height,
    input  wire logic [15:0] i_pixel_format,
    input  wire logic [15:0] i_component_type,
    input  wire logic        o_valid,
    input  wire logic [2:0]  o_status,
    input  wire logic [63:0] o_required_bytes,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic [31:0] prdata,
    input  wire logic        pready,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_nonzero
);

    typedef struct packed {
        tusc_pkg::t_status status;
        logic [63:0]       bytes;
    } t_upload_size;

    // Local copy of the unpack registers, tracked from the configuration port.
    logic [30:0] row_len_m;
    logic [30:0] skip_pix_m;
    logic [30:0] skip_lines_m;
    logic [7:0]  align_m;

    t_upload_size upload_sizes_q[$];
    t_upload_size want;
    logic [31:0]  reg_value;

    function automatic int unsigned channel_count(input logic [15:0] fmt);
        case (fmt)
            tusc_pkg::FMT_ALPHA, tusc_pkg::FMT_LUMINANCE, tusc_pkg::FMT_RED,
            tusc_pkg::FMT_RED_INTEGER, tusc_pkg::FMT_DEPTH_COMPONENT:
                return 1;
            tusc_pkg::FMT_LUMINANCE_ALPHA, tusc_pkg::FMT_RG, tusc_pkg::FMT_RG_INTEGER:
                return 2;
            tusc_pkg::FMT_RGB, tusc_pkg::FMT_RGB_INTEGER:
                return 3;
            tusc_pkg::FMT_RGBA, tusc_pkg::FMT_RGBA_INTEGER:
                return 4;
            default:
                return 0;
        endcase
    endfunction

    // Packed types fix the pixel size on their own; zero means unsupported.
    function automatic int unsigned texel_bytes(input logic [15:0] fmt,
                                                input logic [15:0] typ);
        int unsigned chans;
        case (typ)
            tusc_pkg::TYP_US_5_6_5, tusc_pkg::TYP_US_4_4_4_4, tusc_pkg::TYP_US_5_5_5_1:
                return 2;
            tusc_pkg::TYP_UI_2_10_10_10, tusc_pkg::TYP_UI_10F_11F_11F,
            tusc_pkg::TYP_UI_5_9_9_9, tusc_pkg::TYP_UI_24_8:
                return 4;
            tusc_pkg::TYP_F32_UI_24_8:
                return 8;
            default:
                chans = channel_count(fmt);
        endcase
        case (typ)
            tusc_pkg::TYP_BYTE, tusc_pkg::TYP_UNSIGNED_BYTE:
                return chans;
            tusc_pkg::TYP_SHORT, tusc_pkg::TYP_UNSIGNED_SHORT, tusc_pkg::TYP_HALF_FLOAT:
                return chans * 2;
            tusc_pkg::TYP_INT, tusc_pkg::TYP_UNSIGNED_INT, tusc_pkg::TYP_FLOAT:
                return chans * 4;
            default:
                return 0;
        endcase
    endfunction

    // Everything is worked out exactly in 128 bits and then held against the
    // size limit; all terms are non-negative, so a final sum in range means
    // every partial sum was in range too.
    function automatic t_upload_size predict_upload(input logic [31:0] w,
                                                    input logic [31:0] h,
                                                    input logic [15:0] fmt,
                                                    input logic [15:0] typ);
        logic [127:0] store_w;
        logic [127:0] bpp;
        logic [127:0] align;
        logic [127:0] padded;
        logic [127:0] row;
        logic [127:0] total;
        logic [127:0] limit;
        t_upload_size res;
        res.status = tusc_pkg::ST_OK;
        res.bytes  = '0;
        limit = (128'd1 << tusc_pkg::SIZE_WIDTH) - 128'd1;
        if (w[31] || h[31]) begin
            res.status = tusc_pkg::ST_NEG;
            return res;
        end
        store_w = (row_len_m == '0) ? 128'(w) : 128'(row_len_m);
        if (128'(skip_pix_m) + 128'(w) > store_w) begin
            res.status = tusc_pkg::ST_WINDOW;
            return res;
        end
        if (w == '0 || h == '0) begin
            return res;
        end
        bpp = 128'(texel_bytes(fmt, typ));
        if (bpp == '0) begin
            res.status = tusc_pkg::ST_FMT;
            return res;
        end
        align = 128'(align_m);
        if (align != 1 && align != 2 && align != 4 && align != 8) begin
            res.status = tusc_pkg::ST_ALIGN;
            return res;
        end
        padded = store_w * bpp + align - 128'd1;
        row    = (padded / align) * align;
        total  = 128'(skip_lines_m) * row + 128'(skip_pix_m) * bpp
               + (128'(h) - 128'd1) * row + 128'(w) * bpp;
        if (padded > limit || total > limit) begin
            res.status = tusc_pkg::ST_OVF;
            return res;
        end
        res.bytes = total[63:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_len_m    = '0;
            skip_pix_m   = '0;
            skip_lines_m = '0;
            align_m      = tusc_pkg::ALIGN_RESET;
            upload_sizes_q.delete();
            o_fail_count = 0;
            o_checked    = 0;
            o_nonzero    = 0;
        end else begin
            if ($isunknown(o_valid)) begin
                o_fail_count++;
                $display("%0t: result strobe unknown, expected 0 or 1, got %b", $time, o_valid);
            end else if (o_valid) begin
                if (upload_sizes_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: result word with none expected, got status %0d bytes %0d",
                             $time, o_status, o_required_bytes);
                end else begin
                    want = upload_sizes_q.pop_front();
                    o_checked++;
                    if (want.bytes != '0) begin
                        o_nonzero++;
                    end
                    if (o_status !== want.status) begin
                        o_fail_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, o_status);
                    end
                    if (o_required_bytes !== want.bytes) begin
                        o_fail_count++;
                        $display("%0t: required_bytes mismatch, expected %0d, got %0d",
                                 $time, want.bytes, o_required_bytes);
                    end
                end
            end
            if (start && !busy) begin
                upload_sizes_q.push_back(predict_upload(i_width, i_height,
                                                        i_pixel_format, i_component_type));
            end
            if (psel && penable && pready) begin
                case (paddr[3:2])
                    tusc_pkg::REG_STRIDE:     reg_value = {1'b0, row_len_m};
                    tusc_pkg::REG_SKIP_PX:    reg_value = {1'b0, skip_pix_m};
                    tusc_pkg::REG_SKIP_LINES: reg_value = {1'b0, skip_lines_m};
                    default:                  reg_value = {24'd0, align_m};
                endcase
                if (pwrite) begin
                    case (paddr[3:2])
                        tusc_pkg::REG_STRIDE:     row_len_m    = pwdata[30:0];
                        tusc_pkg::REG_SKIP_PX:    skip_pix_m   = pwdata[30:0];
                        tusc_pkg::REG_SKIP_LINES: skip_lines_m = pwdata[30:0];
                        default:                  align_m      = pwdata[7:0];
                    endcase
                end else if (prdata !== reg_value) begin
                    o_fail_count++;
                    $display("%0t: register %0d read back, expected %0d, got %0d",
                             $time, paddr[3:2], reg_value, prdata);
                end
            end
        end
        o_pending = upload_sizes_q.size();
    end

endmodule

`default_nettype wire

// File: verif/texture_unpack_size_calc_unit_test.sv
`default_nettype none

// Stimulus and verdict for the texture upload size unit. The checker beside
// the block and the assertions bound into it do all checking; this module only
// creates request words, programs the unpack registers and reports the outcome.
module texture_unpack_size_calc_unit_test;

    // Clock, reset and every block input start at known values.
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        start            = 1'b0;
    logic [31:0] i_width          = '0;
    logic [31:0] i_height         = '0;
    logic [15:0] i_pixel_format   = '0;
    logic [15:0] i_component_type = '0;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [3:0]  paddr            = '0;
    logic [31:0] pwdata           = '0;

    logic        busy;
    logic        o_valid;
    logic [2:0]  o_status;
    logic [63:0] o_required_bytes;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending_words;
    int checked_words;
    int nonzero_words;

    // Stimulus-side view of the unpack registers, used only to shape the
    // random request words so that most of them get past the early checks.
    logic [31:0] cfg_row_len   = '0;
    logic [31:0] cfg_skip_pix  = '0;

    int request_words = 0;
    int unpack_settings = 1;

    texture_unpack_size_calc_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_width          (i_width),
        .i_height         (i_height),
        .i_pixel_format   (i_pixel_format),
        .i_component_type (i_component_type),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_required_bytes (o_required_bytes),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    texture_unpack_size_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_width          (i_width),
        .i_height         (i_height),
        .i_pixel_format   (i_pixel_format),
        .i_component_type (i_component_type),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_required_bytes (o_required_bytes),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_fail_count     (fail_count),
        .o_pending        (pending_words),
        .o_checked        (checked_words),
        .o_nonzero        (nonzero_words)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake or a result word never arrives.
    initial begin
        #400000;
        $display("texture_unpack_size_calc_unit_test: FAIL");
        $finish;
    end

    // Every task below is entered right after a rising edge with no pending
    // assignment in that time step, and leaves the same way. That keeps each
    // signal to a single nonblocking assignment per step.

    // Present one request word and hold it until the block takes it. busy
    // only moves at rising edges, so its value at the falling edge is what
    // the next rising edge sees.
    task automatic issue_request(input logic [31:0] w, input logic [31:0] h,
                                 input logic [15:0] fmt, input logic [15:0] typ);
        bit taken;
        start            <= 1'b1;
        i_width          <= w;
        i_height         <= h;
        i_pixel_format   <= fmt;
        i_component_type <= typ;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        request_words++;
    endtask

    // Stop sending and wait until every predicted result word has been seen,
    // then let the pipeline latency pass once more before touching registers.
    task automatic quiesce();
        int spins;
        start <= 1'b0;
        spins = 0;
        @(negedge i_clk);
        while (pending_words != 0 && spins < 2000) begin
            @(negedge i_clk);
            spins++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then the access cycle; pready is tied high, so
    // the register takes the data at the edge that ends the access cycle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            tusc_pkg::REG_STRIDE:  cfg_row_len  = {1'b0, data[30:0]};
            tusc_pkg::REG_SKIP_PX: cfg_skip_pix = {1'b0, data[30:0]};
            default: ;
        endcase
    endtask

    // APB read; the checker compares prdata with its own register copy.
    task automatic read_reg(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic read_all_regs();
        read_reg(tusc_pkg::REG_STRIDE);
        read_reg(tusc_pkg::REG_SKIP_PX);
        read_reg(tusc_pkg::REG_SKIP_LINES);
        read_reg(tusc_pkg::REG_ROW_ALIGNMENT);
    endtask

    // A pixel count up to cap: mostly small, sometimes zero, the cap itself
    // or anywhere in the range.
    function automatic logic [31:0] pick_extent(input logic [31:0] cap);
        int unsigned r;
        r = $urandom_range(99);
        if (cap == '0 || r < 5) begin
            return '0;
        end
        if (r < 10) begin
            return cap;
        end
        if (r < 85) begin
            return $urandom_range((cap < 64) ? cap : 64, 1);
        end
        return $urandom_range(cap);
    endfunction

    function automatic logic [15:0] pick_format();
        case ($urandom_range(11))
            0:       return tusc_pkg::FMT_ALPHA;
            1:       return tusc_pkg::FMT_LUMINANCE;
            2:       return tusc_pkg::FMT_RED;
            3:       return tusc_pkg::FMT_RED_INTEGER;
            4:       return tusc_pkg::FMT_DEPTH_COMPONENT;
            5:       return tusc_pkg::FMT_LUMINANCE_ALPHA;
            6:       return tusc_pkg::FMT_RG;
            7:       return tusc_pkg::FMT_RG_INTEGER;
            8:       return tusc_pkg::FMT_RGB;
            9:       return tusc_pkg::FMT_RGB_INTEGER;
            10:      return tusc_pkg::FMT_RGBA;
            default: return tusc_pkg::FMT_RGBA_INTEGER;
        endcase
    endfunction

    function automatic logic [15:0] pick_type();
        case ($urandom_range(15))
            0:       return tusc_pkg::TYP_BYTE;
            1:       return tusc_pkg::TYP_UNSIGNED_BYTE;
            2:       return tusc_pkg::TYP_SHORT;
            3:       return tusc_pkg::TYP_UNSIGNED_SHORT;
            4:       return tusc_pkg::TYP_INT;
            5:       return tusc_pkg::TYP_UNSIGNED_INT;
            6:       return tusc_pkg::TYP_FLOAT;
            7:       return tusc_pkg::TYP_HALF_FLOAT;
            8:       return tusc_pkg::TYP_US_4_4_4_4;
            9:       return tusc_pkg::TYP_US_5_5_5_1;
            10:      return tusc_pkg::TYP_US_5_6_5;
            11:      return tusc_pkg::TYP_UI_2_10_10_10;
            12:      return tusc_pkg::TYP_UI_24_8;
            13:      return tusc_pkg::TYP_UI_10F_11F_11F;
            14:      return tusc_pkg::TYP_UI_5_9_9_9;
            default: return tusc_pkg::TYP_F32_UI_24_8;
        endcase
    endfunction

    // New random unpack settings. Skip pixels usually stay inside the stored
    // row so that the row window check lets most requests through. The upper
    // data bits that the registers drop are filled with noise.
    task automatic program_random_settings();
        logic [31:0] row_len;
        logic [31:0] skip_pix;
        logic [31:0] skip_lines;
        logic [31:0] align;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 35)      row_len = '0;
        else if (r < 75) row_len = $urandom_range(4096, 1);
        else if (r < 90) row_len = $urandom_range(32'h7FFF_FFFF);
        else             row_len = 32'h7FFF_FFFF;
        r = $urandom_range(99);
        if (row_len == '0) begin
            skip_pix = (r < 85) ? '0 : $urandom_range(16, 1);
        end else if (r < 40) begin
            skip_pix = '0;
        end else if (r < 85) begin
            skip_pix = $urandom_range(row_len);
        end else begin
            skip_pix = $urandom_range(32'h7FFF_FFFF);
        end
        r = $urandom_range(99);
        if (r < 40)      skip_lines = '0;
        else if (r < 80) skip_lines = $urandom_range(64);
        else if (r < 92) skip_lines = $urandom_range(32'h7FFF_FFFF);
        else             skip_lines = 32'h7FFF_FFFF;
        if ($urandom_range(99) < 85) begin
            align = 32'd1 << $urandom_range(3);
        end else begin
            align = $urandom_range(255);
        end
        write_reg(tusc_pkg::REG_STRIDE,        {1'($urandom_range(1)), row_len[30:0]});
        write_reg(tusc_pkg::REG_SKIP_PX,       {1'($urandom_range(1)), skip_pix[30:0]});
        write_reg(tusc_pkg::REG_SKIP_LINES,    {1'($urandom_range(1)), skip_lines[30:0]});
        write_reg(tusc_pkg::REG_ROW_ALIGNMENT, {24'($urandom), align[7:0]});
        unpack_settings++;
    endtask

    // One batch of random request words under the current settings. Three in
    // four are well formed with random content; the rest are raw noise that
    // hits negative sizes, unknown enums and every bit of every field.
    task automatic run_random_batch(input int count, input bit with_gaps);
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] cap;
        logic [15:0] fmt;
        logic [15:0] typ;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 75) begin
                if (cfg_row_len == '0) begin
                    cap = (cfg_skip_pix == '0) ? 32'h7FFF_FFFF : 32'd64;
                end else if (cfg_skip_pix <= cfg_row_len) begin
                    cap = cfg_row_len - cfg_skip_pix;
                end else begin
                    cap = '0;
                end
                w   = pick_extent(cap);
                h   = pick_extent(32'h7FFF_FFFF);
                fmt = pick_format();
                typ = pick_type();
            end else begin
                w   = $urandom;
                h   = $urandom;
                fmt = ($urandom_range(1) != 0) ? 16'($urandom) : pick_format();
                typ = ($urandom_range(1) != 0) ? 16'($urandom) : pick_type();
            end
            issue_request(w, h, fmt, typ);
            // Idle roughly a third of the time, with junk on the payload.
            if (with_gaps && $urandom_range(99) < 32) begin
                start            <= 1'b0;
                i_width          <= $urandom;
                i_height         <= $urandom;
                i_pixel_format   <= 16'($urandom);
                i_component_type <= 16'($urandom);
                repeat ($urandom_range(2, 1)) @(posedge i_clk);
            end
        end
        quiesce();
    endtask

    initial begin
        // Synchronous reset, held once at the start.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values of the unpack registers.
        read_all_regs();

        // Directed words under the reset settings: empty images win over
        // format errors, negative sizes come first, packed types ignore the
        // format, and the largest image overflows.
        issue_request(32'd0, 32'd5, tusc_pkg::FMT_RGBA, tusc_pkg::TYP_UNSIGNED_BYTE);
        issue_request(32'd7, 32'd0, 16'hFFFF, 16'hFFFF);
        issue_request(32'hFFFF_FFFF, 32'd1, tusc_pkg::FMT_RGBA, tusc_pkg::TYP_UNSIGNED_BYTE);
        issue_request(32'd1, 32'h8000_0000, tusc_pkg::FMT_RGBA, tusc_pkg::TYP_UNSIGNED_BYTE);
        issue_request(32'd3, 32'd2, tusc_pkg::FMT_RGB, tusc_pkg::TYP_UNSIGNED_BYTE);
        issue_request(32'd1, 32'd1, 16'h0000, tusc_pkg::TYP_UNSIGNED_BYTE);
        issue_request(32'd1, 32'd1, tusc_pkg::FMT_RGBA, 16'h0000);
        issue_request(32'd5, 32'd3, 16'hFFFF, tusc_pkg::TYP_US_5_6_5);
        issue_request(32'd2, 32'd2, tusc_pkg::FMT_DEPTH_COMPONENT, tusc_pkg::TYP_F32_UI_24_8);
        issue_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, tusc_pkg::FMT_RGBA, tusc_pkg::TYP_FLOAT);
        issue_request(32'h7FFF_FFFF, 32'd1, tusc_pkg::FMT_RED, tusc_pkg::TYP_UNSIGNED_BYTE);
        quiesce();

        // Alignment outside 1, 2, 4 and 8, at both ends of the register.
        write_reg(tusc_pkg::REG_ROW_ALIGNMENT, 32'd0);
        issue_request(32'd1, 32'd1, tusc_pkg::FMT_RGBA, tusc_pkg::TYP_UNSIGNED_BYTE);
        quiesce();
        write_reg(tusc_pkg::REG_ROW_ALIGNMENT, 32'hFFFF_FFFF);
        read_reg(tusc_pkg::REG_ROW_ALIGNMENT);
        issue_request(32'd4, 32'd4, tusc_pkg::FMT_RG, tusc_pkg::TYP_SHORT);
        issue_request(32'd0, 32'd4, tusc_pkg::FMT_RG, tusc_pkg::TYP_SHORT);
        quiesce();

        // A stored row of 100 pixels with skips: the window just fits, just
        // overflows, and a negative width still reports the size error.
        write_reg(tusc_pkg::REG_STRIDE, 32'd100);
        write_reg(tusc_pkg::REG_SKIP_PX, 32'd20);
        write_reg(tusc_pkg::REG_SKIP_LINES, 32'd7);
        write_reg(tusc_pkg::REG_ROW_ALIGNMENT, 32'd8);
        issue_request(32'd80, 32'd4, tusc_pkg::FMT_RG, tusc_pkg::TYP_SHORT);
        issue_request(32'd81, 32'd4, tusc_pkg::FMT_RG, tusc_pkg::TYP_SHORT);
        issue_request(32'hFFFF_FFFB, 32'd4, tusc_pkg::FMT_RG, tusc_pkg::TYP_SHORT);
        quiesce();

        // Largest row length and skipped rows: the byte count nears the top of
        // the 64-bit range and crosses it with wide pixels.
        write_reg(tusc_pkg::REG_STRIDE, 32'hFFFF_FFFF);
        write_reg(tusc_pkg::REG_SKIP_PX, 32'd0);
        write_reg(tusc_pkg::REG_SKIP_LINES, 32'hFFFF_FFFF);
        write_reg(tusc_pkg::REG_ROW_ALIGNMENT, 32'd1);
        read_all_regs();
        issue_request(32'd1, 32'd1, tusc_pkg::FMT_RED, tusc_pkg::TYP_UNSIGNED_BYTE);
        issue_request(32'd1, 32'd1, tusc_pkg::FMT_RGBA, tusc_pkg::TYP_FLOAT);
        issue_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, tusc_pkg::FMT_RED,
                      tusc_pkg::TYP_UNSIGNED_BYTE);
        quiesce();

        // Skip pixels filling the whole row leaves room only for an empty one.
        write_reg(tusc_pkg::REG_SKIP_PX, 32'h7FFF_FFFF);
        issue_request(32'd0, 32'd3, tusc_pkg::FMT_RGBA, tusc_pkg::TYP_UNSIGNED_BYTE);
        issue_request(32'd1, 32'd3, tusc_pkg::FMT_RGBA, tusc_pkg::TYP_UNSIGNED_BYTE);
        quiesce();
        unpack_settings += 5;

        // Random part: a fresh setting per batch, one batch back to back.
        for (int b = 0; b < 8; b++) begin
            program_random_settings();
            read_all_regs();
            run_random_batch(154, b != 3);
        end

        repeat (4) @(posedge i_clk);
        $display("Covered %0d request words under %0d unpack settings.",
                 request_words, unpack_settings);
        $display("Checked %0d result words, %0d of them with a nonzero byte count.",
                 checked_words, nonzero_words);
        if (fail_count == 0 && pending_words == 0) begin
            $display("texture_unpack_size_calc_unit_test: PASS");
        end else begin
            $display("texture_unpack_size_calc_unit_test: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
